/* src/plst_pkg.sv */
`default_nettype none

package plst_pkg;

  // Fixed field widths of the request and result ports
  localparam int OP_W   = 3;
  localparam int POS_W  = 11;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
  localparam logic [OP_W-1:0] OP_LOCATE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  // What every cell of the row does in a given cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_mode_t;

endpackage

`default_nettype wire

/* src/positional_list_store.sv */
`default_nettype none

// Ordered list of element words, positions counted from 1, with an entry count.
// Request channel: operation, position and element are taken at a rising edge
// with start high and busy low; busy stays high until the result is out.
// Result channel: status, element_out, found_position and item_count are
// valid for exactly one cycle while done is high; the receiver cannot stall,
// and a new request may be issued in the cycle that done is high.
// Entries live in a row of cells. Insert opens a gap and delete closes one by
// shifting all cells from that position on at once; retrieve, delete and locate
// rotate occupied cells via the head cell, one entry a cycle, to original order.
// Sequence of a request: it is latched, then decoded; insert, clear, unused codes
// and rejected requests finish at decode, retrieve and locate after the rotation,
// and delete after the rotation and a shift that closes the gap.
// Reset (rst, synchronous) empties the list; no clearing pass is needed since
// only occupied cells are ever read.
module positional_list_store
  import plst_pkg::*;
#(
  parameter int LIST_CAPACITY = 1024,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] element,
  output logic                   busy,
  output logic                   done,
  output logic [STAT_W-1:0]      status,
  output logic [DATA_W-1:0]      element_out,
  output logic [POS_W-1:0]       found_position,
  output logic [POS_W-1:0]       item_count
);

  localparam int CW = $clog2(LIST_CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  cell_mode_t               cell_mode;
  logic [XW-1:0]            sel_pos;
  logic [XW-1:0]            cur_count;
  logic [ELEMENT_WIDTH-1:0] key_word;
  logic [ELEMENT_WIDTH-1:0] cell_word [LIST_CAPACITY];

  plst_ctrl #(
    .CAP (LIST_CAPACITY),
    .EW  (ELEMENT_WIDTH),
    .XW  (XW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .operation      (operation),
    .position       (position),
    .element        (element),
    .head_word      (cell_word[0]),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .element_out    (element_out),
    .found_position (found_position),
    .item_count     (item_count),
    .cell_mode      (cell_mode),
    .sel_pos        (sel_pos),
    .cur_count      (cur_count),
    .key_word       (key_word)
  );

  // Row of entry cells; the first cell never selects its tied-off prev input
  for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] prev_w;
    logic [ELEMENT_WIDTH-1:0] next_w;

    if (g == 0) begin : g_first
      assign prev_w = key_word;
    end else begin : g_mid_prev
      assign prev_w = cell_word[g-1];
    end

    if (g == LIST_CAPACITY - 1) begin : g_last
      assign next_w = cell_word[g];
    end else begin : g_mid_next
      assign next_w = cell_word[g+1];
    end

    plst_cell #(
      .EW    (ELEMENT_WIDTH),
      .XW    (XW),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .mode      (cell_mode),
      .sel_pos   (sel_pos),
      .cur_count (cur_count),
      .elem_in   (key_word),
      .prev_word (prev_w),
      .next_word (next_w),
      .head_word (cell_word[0]),
      .word      (cell_word[g])
    );
  end

endmodule

`default_nettype wire

/* src/plst_cell.sv */
`default_nettype none

module plst_cell
  import plst_pkg::*;
#(
  parameter int EW    = 32,
  parameter int XW    = 14,
  parameter int INDEX = 0
) (
  input  wire logic          clk,
  input  wire cell_mode_t    mode,
  input  wire logic [XW-1:0] sel_pos,
  input  wire logic [XW-1:0] cur_count,
  input  wire logic [EW-1:0] elem_in,
  input  wire logic [EW-1:0] prev_word,
  input  wire logic [EW-1:0] next_word,
  input  wire logic [EW-1:0] head_word,
  output logic      [EW-1:0] word
);

  // One-based place of this cell in the list
  localparam logic [XW-1:0] PLACE = XW'(INDEX + 1);

  // Entry register: hold, open a gap, close a gap or rotate the occupied part
  always_ff @(posedge clk) begin
    unique case (mode)
      CM_INSERT: begin
        if (PLACE > sel_pos) begin
          word <= prev_word;
        end else if (PLACE == sel_pos) begin
          word <= elem_in;
        end
      end
      CM_DELETE: begin
        if (PLACE >= sel_pos) begin
          word <= next_word;
        end
      end
      CM_ROTATE: begin
        if (PLACE < cur_count) begin
          word <= next_word;
        end else if (PLACE == cur_count) begin
          word <= head_word;
        end
      end
      CM_HOLD: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/plst_ctrl.sv */
`default_nettype none

module plst_ctrl
  import plst_pkg::*;
#(
  parameter int CAP = 1024,
  parameter int EW  = 32,
  parameter int XW  = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DATA_W-1:0] element,
  input  wire logic [EW-1:0]     head_word,
  output logic                   busy,
  output logic                   done,
  output logic [STAT_W-1:0]      status,
  output logic [DATA_W-1:0]      element_out,
  output logic [POS_W-1:0]       found_position,
  output logic [POS_W-1:0]       item_count,
  output cell_mode_t             cell_mode,
  output logic [XW-1:0]          sel_pos,
  output logic [XW-1:0]          cur_count,
  output logic [EW-1:0]          key_word
);

  localparam int CW = $clog2(CAP + 1);
  localparam logic [XW-1:0] CAP_X = XW'(CAP);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t            state;
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     step;
  logic              hit;

  logic [XW-1:0]     step_x;
  logic              ins_ok;
  logic              ins_range;
  logic              acc_ok;
  logic              last_step;
  logic              head_match;

  assign busy      = (state != S_IDLE);
  assign sel_pos   = XW'(pos_q);
  assign cur_count = XW'(count);
  assign step_x    = XW'(step);

  // Range and capacity checks on the latched request, scan end and head compare
  assign ins_range  = (sel_pos != '0) && (sel_pos <= cur_count + 1'b1);
  assign ins_ok     = ins_range && (cur_count < CAP_X);
  assign acc_ok     = (sel_pos != '0) && (sel_pos <= cur_count);
  assign last_step  = (step_x + 1'b1 == cur_count);
  assign head_match = (head_word == key_word);

  // Row command
  always_comb begin
    cell_mode = CM_HOLD;
    unique case (state)
      S_DECODE: begin
        if (op_q == OP_INSERT && ins_ok) begin
          cell_mode = CM_INSERT;
        end
      end
      S_SCAN:  cell_mode = CM_ROTATE;
      S_SHIFT: cell_mode = CM_DELETE;
      S_IDLE:  cell_mode = CM_HOLD;
    endcase
  end

  // Sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q     <= operation;
            pos_q    <= position;
            key_word <= EW'(element);
            state    <= S_DECODE;
          end
        end

        S_DECODE: begin
          step           <= '0;
          hit            <= 1'b0;
          element_out    <= '0;
          found_position <= '0;
          status         <= ST_OK;
          item_count     <= POS_W'(count);
          unique case (op_q)
            OP_INSERT: begin
              if (!ins_range) begin
                status <= ST_RANGE;
              end else if (!ins_ok) begin
                status <= ST_FULL;
              end else begin
                count      <= count + 1'b1;
                item_count <= POS_W'(cur_count + 1'b1);
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            OP_DELETE, OP_RETRIEVE: begin
              if (acc_ok) begin
                state <= S_SCAN;
              end else begin
                status <= ST_RANGE;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            OP_LOCATE: begin
              if (count != '0) begin
                state <= S_SCAN;
              end else begin
                status <= ST_NOTFOUND;
                done   <= 1'b1;
                state  <= S_IDLE;
              end
            end
            OP_CLEAR: begin
              count      <= '0;
              item_count <= '0;
              done       <= 1'b1;
              state      <= S_IDLE;
            end
            default: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end

        // Head cell holds entry number step + 1 this cycle
        S_SCAN: begin
          step <= step + 1'b1;
          if (op_q == OP_LOCATE) begin
            if (!hit && head_match) begin
              hit            <= 1'b1;
              found_position <= POS_W'(step_x + 1'b1);
            end
          end else if (step_x + 1'b1 == sel_pos) begin
            element_out <= DATA_W'(head_word);
          end
          if (last_step) begin
            if (op_q == OP_DELETE) begin
              state <= S_SHIFT;
            end else begin
              status <= (op_q == OP_LOCATE && !hit && !head_match) ? ST_NOTFOUND : ST_OK;
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end
        end

        S_SHIFT: begin
          count      <= count - 1'b1;
          item_count <= POS_W'(cur_count - 1'b1);
          status     <= ST_OK;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/positional_list_store_tb.sv */
module positional_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plst_pkg::*;

  localparam int CAPACITY = 1024;
  localparam int POOL_SIZE = 8;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 16;

  // One request and one result, field for field
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] word;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic [DATA_W-1:0] word;
    logic [POS_W-1:0]  found;
    logic [POS_W-1:0]  count;
  } list_rsp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [OP_W-1:0]   operation = OP_CLEAR;
  logic [POS_W-1:0]  position = '0;
  logic [DATA_W-1:0] element = '0;
  logic              busy;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] element_out;
  logic [POS_W-1:0]  found_position;
  logic [POS_W-1:0]  item_count;

  list_req_t         request_backlog[$];
  list_rsp_t         awaited_results[$];
  logic [DATA_W-1:0] shadow_list[$];
  logic [DATA_W-1:0] word_pool[POOL_SIZE];

  logic   req_taken = 1'b0;
  int     sent_count = 0;
  int     result_count = 0;
  int     fail_count = 0;
  int     plan_count = 0;
  longint cycle_bound = 0;
  longint cycle_limit = 64'd1_000_000_000;
  longint cycle_count = 0;

  positional_list_store #(
    .LIST_CAPACITY(CAPACITY),
    .ELEMENT_WIDTH(DATA_W)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .operation     (operation),
    .position      (position),
    .element       (element),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .element_out   (element_out),
    .found_position(found_position),
    .item_count    (item_count)
  );

  always #1 clk = ~clk;

  // Applies one request to the shadow list and gives the result it should yield
  function automatic list_rsp_t list_outcome(list_req_t req);
    list_rsp_t rsp;
    int n;
    int p;
    rsp = '0;
    rsp.stat = ST_OK;
    n = shadow_list.size();
    p = int'(req.pos);
    case (req.op)
      OP_INSERT: begin
        if (p < 1 || p > n + 1) rsp.stat = ST_RANGE;
        else if (n >= CAPACITY) rsp.stat = ST_FULL;
        else shadow_list.insert(p - 1, req.word);
      end
      OP_DELETE: begin
        if (p < 1 || p > n) begin
          rsp.stat = ST_RANGE;
        end else begin
          rsp.word = shadow_list[p - 1];
          shadow_list.delete(p - 1);
        end
      end
      OP_RETRIEVE: begin
        if (p < 1 || p > n) rsp.stat = ST_RANGE;
        else rsp.word = shadow_list[p - 1];
      end
      OP_LOCATE: begin
        rsp.stat = ST_NOTFOUND;
        for (int i = 0; i < n; i++) begin
          if (shadow_list[i] == req.word) begin
            rsp.found = POS_W'(i + 1);
            rsp.stat = ST_OK;
            break;
          end
        end
      end
      OP_CLEAR: begin
        shadow_list.delete();
      end
      default: ;
    endcase
    rsp.count = POS_W'(shadow_list.size());
    return rsp;
  endfunction

  function automatic void flag_fault(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Queues a request and follows the list length so later requests can be well formed
  task automatic plan_request(input logic [OP_W-1:0] op, input int pos,
                              input logic [DATA_W-1:0] word);
    list_req_t r;
    r.op = op;
    r.pos = pos[POS_W-1:0];
    r.word = word;
    request_backlog.push_back(r);
    // worst case of a delete, which scans the whole list and then shifts, plus slack
    cycle_bound += 4 + plan_count;
    case (op)
      OP_INSERT: begin
        if (r.pos >= 1 && r.pos <= plan_count + 1 && plan_count < CAPACITY) plan_count++;
      end
      OP_DELETE: begin
        if (r.pos >= 1 && r.pos <= plan_count) plan_count--;
      end
      OP_CLEAR: plan_count = 0;
      default: ;
    endcase
  endtask

  // Mostly words from a small pool so that locate finds something
  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(99) < 70) return word_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic random_request();
    int roll;
    int pos;
    logic [OP_W-1:0] op;
    roll = $urandom_range(99);
    // insert outweighs delete, but the list is capped near 48 to keep scans short
    if (roll < 40) op = (plan_count >= 48) ? OP_DELETE : OP_INSERT;
    else if (roll < 60) op = OP_DELETE;
    else if (roll < 76) op = OP_RETRIEVE;
    else if (roll < 92) op = OP_LOCATE;
    else if (roll < 94) op = OP_CLEAR;
    else if (roll < 97) op = OP_W'($urandom_range(7, 5));
    else op = OP_W'($urandom_range(7));
    if ($urandom_range(99) < 88) begin
      if (op == OP_INSERT) pos = $urandom_range(plan_count + 1, 1);
      else pos = $urandom_range((plan_count > 0) ? plan_count : 1, 1);
    end else begin
      pos = $urandom_range(2047);
    end
    plan_request(op, pos, (op == OP_INSERT || op == OP_LOCATE) ? pick_word() : $urandom);
  endtask

  // Stimulus, then the wait for the last results and the verdict
  initial begin
    word_pool[0] = '0;
    word_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) word_pool[i] = $urandom;

    // directed: empty list, edges of position, every operation
    plan_request(OP_RETRIEVE, 1, 32'h0);
    plan_request(OP_DELETE, 0, 32'h0);
    plan_request(OP_LOCATE, 0, 32'h1234_5678);
    plan_request(OP_INSERT, 0, 32'hDEAD_BEEF);
    plan_request(OP_INSERT, 2, 32'hDEAD_BEEF);
    plan_request(OP_INSERT, 1, 32'hFFFF_FFFF);
    plan_request(OP_INSERT, 2, 32'h0000_0000);
    plan_request(OP_INSERT, 1, 32'hA5A5_A5A5);
    plan_request(OP_INSERT, 2, 32'h5A5A_5A5A);
    plan_request(OP_RETRIEVE, 4, 32'h0);
    plan_request(OP_RETRIEVE, 5, 32'h0);
    plan_request(OP_RETRIEVE, 2047, 32'hFFFF_FFFF);
    plan_request(OP_LOCATE, 0, 32'hFFFF_FFFF);
    plan_request(OP_LOCATE, 1, 32'h1234_5678);
    plan_request(3'd5, 1, $urandom);
    plan_request(3'd6, 0, $urandom);
    plan_request(3'd7, 2047, $urandom);
    plan_request(OP_DELETE, 4, 32'h0);
    plan_request(OP_DELETE, 1, 32'h0);
    plan_request(OP_DELETE, 1025, 32'h0);
    plan_request(OP_INSERT, 1025, 32'h0F0F_0F0F);
    plan_request(OP_CLEAR, 3, 32'h0);
    plan_request(OP_RETRIEVE, 1, 32'h0);

    repeat (395) random_request();

    // fill to capacity, exercise the full list, then empty it again
    plan_request(OP_CLEAR, $urandom_range(2047), $urandom);
    while (plan_count < CAPACITY) plan_request(OP_INSERT, $urandom_range(plan_count + 1, 1),
                                               pick_word());
    plan_request(OP_INSERT, $urandom_range(CAPACITY, 1), $urandom);
    plan_request(OP_INSERT, CAPACITY + 1, $urandom);
    plan_request(OP_INSERT, CAPACITY + 2, $urandom);
    plan_request(OP_INSERT, 0, $urandom);
    plan_request(OP_RETRIEVE, CAPACITY, $urandom);
    plan_request(OP_RETRIEVE, 1, $urandom);
    plan_request(OP_LOCATE, 0, word_pool[$urandom_range(POOL_SIZE - 1)]);
    plan_request(OP_LOCATE, 0, 32'h0BAD_F00D);
    plan_request(OP_DELETE, CAPACITY, $urandom);
    plan_request(OP_INSERT, CAPACITY, $urandom);
    plan_request(OP_DELETE, CAPACITY / 2, $urandom);
    plan_request(OP_CLEAR, 0, $urandom);

    repeat (395) random_request();

    cycle_limit = 4 * cycle_bound + 20000;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || start || awaited_results.size() != 0)
      @(negedge clk);
    // a stray result would show up here as unexpected
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("** positional_list_store: PASSED **");
    end else begin
      $display("** positional_list_store: FAILED **");
    end
    $finish;
  end

  // Request driver: changes inputs on the falling edge
  always @(negedge clk) begin
    list_req_t next_req;
    logic idle;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      // no idling over a long run of requests in the middle
      idle = ($urandom_range(99) < 26) && !(sent_count >= 300 && sent_count < 700);
      if (request_backlog.size() != 0 && !idle) begin
        next_req = request_backlog.pop_front();
        start <= 1'b1;
        operation <= next_req.op;
        position <= next_req.pos;
        element <= next_req.word;
        sent_count++;
      end else begin
        start <= 1'b0;
        operation <= OP_W'($urandom);
        position <= POS_W'($urandom);
        element <= $urandom;
      end
    end
  end

  // Result checker and predictor, on the rising edge
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (done) begin
        got = '{status, element_out, found_position, item_count};
        if (awaited_results.size() == 0) begin
          flag_fault($sformatf("result %0d with no request outstanding: status %0d count %0d",
                               result_count, got.stat, got.count));
        end else begin
          want = awaited_results.pop_front();
          if (got.stat !== want.stat || got.word !== want.word ||
              got.found !== want.found || got.count !== want.count)
            flag_fault($sformatf({"result %0d mismatch (expected/actual): status %0d/%0d ",
                                  "element_out %h/%h found_position %0d/%0d ",
                                  "item_count %0d/%0d"},
                                 result_count, want.stat, got.stat, want.word, got.word,
                                 want.found, got.found, want.count, got.count));
        end
        result_count++;
      end
      if (start && !busy) awaited_results.push_back(list_outcome('{operation, position, element}));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("** positional_list_store: FAILED **");
      $finish;
    end
  end

endmodule
